/* rtl/dqp_pkg.sv */
package dqp_pkg;

  // Default maximum name length in bytes, terminator included (64..256)
  localparam int MAX_NAME_BYTES_DEF = 256;

  // Largest label length byte; anything above is a pointer or reserved
  localparam logic [7:0] MAX_LABEL_LEN = 8'd63;

  localparam int HDR_BYTES = 12;

  typedef enum logic [2:0] {
    EV_HDR_OK   = 3'd0,
    EV_CHAR     = 3'd1,
    EV_QDONE    = 3'd2,
    EV_REJECT   = 3'd3,
    EV_TOOLONG  = 3'd4,
    EV_BADLABEL = 3'd5,
    EV_TRUNC    = 3'd6
  } evt_t;

  typedef struct packed {
    evt_t        event_res;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic        qr_bit;
    logic [3:0]  op_code;
    logic        aa_bit;
    logic        tc_bit;
    logic        rd_bit;
    logic        ra_bit;
    logic [3:0]  resp_code;
    logic        last_question;
  } result_t;

endpackage

/* rtl/dqp_skid.sv */
module dqp_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dqp_pkg::result_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dqp_pkg::result_t  out_data
);
  import dqp_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // ready comes straight off a flop
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

/* rtl/dns_query_parser.sv */
// Each result is registered at the output, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty, set by the single-pass
// parse logic feeding the result register; a two-entry output stage keeps bytes flowing
// while one result waits. Reset: synchronous, active high; returns the parser to the header
// phase with all counters cleared and empties the output stage.
module dns_query_parser #(
  parameter int MAX_NAME_BYTES = dqp_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: message bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // message_end
  // master side: parse events
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] word_a, [31:16] word_b, [47:32] word_c,
                                 // [48] qr_bit, [52:49] op_code, [53] aa_bit,
                                 // [54] tc_bit, [55] rd_bit, [56] ra_bit,
                                 // [60:57] resp_code, [63:61] zero
  output logic [2:0]  m_tuser,   // [2:0] event_res
  output logic        m_tlast    // last_question
);
  import dqp_pkg::*;

  localparam int NPOS_W = $clog2(MAX_NAME_BYTES);
  localparam logic [NPOS_W-1:0] NPOS_LIMIT = NPOS_W'(MAX_NAME_BYTES - 1);
  localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  // parser state
  phase_t            phase, phase_next;
  logic [3:0]        hdr_idx, hdr_idx_next;
  logic [15:0]       hdr_id, hdr_id_next;
  logic [15:0]       hdr_flags, hdr_flags_next;
  logic [15:0]       hdr_qd, hdr_qd_next;
  logic [7:0]        ar_hi, ar_hi_next;
  logic              anns_nz, anns_nz_next;   // answer or authority count nonzero
  logic [15:0]       q_left, q_left_next;
  logic [NPOS_W-1:0] name_pos, name_pos_next;
  logic [5:0]        label_left, label_left_next;
  logic [23:0]       tail, tail_next;         // first three bytes of qtype/qclass
  logic [1:0]        tail_idx, tail_idx_next;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    buf_ready;
  logic [7:0] b;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = buf_ready;
  assign b        = s_tdata;

  always_comb begin
    phase_next      = phase;
    hdr_idx_next    = hdr_idx;
    hdr_id_next     = hdr_id;
    hdr_flags_next  = hdr_flags;
    hdr_qd_next     = hdr_qd;
    ar_hi_next      = ar_hi;
    anns_nz_next    = anns_nz;
    q_left_next     = q_left;
    name_pos_next   = name_pos;
    label_left_next = label_left;
    tail_next       = tail;
    tail_idx_next   = tail_idx;
    res             = '0;
    res_valid       = 1'b0;

    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          hdr_idx_next = hdr_idx + 4'd1;
          case (hdr_idx) inside
            4'd0:  hdr_id_next[15:8]    = b;
            4'd1:  hdr_id_next[7:0]     = b;
            4'd2:  hdr_flags_next[15:8] = b;
            4'd3:  hdr_flags_next[7:0]  = b;
            4'd4:  hdr_qd_next[15:8]    = b;
            4'd5:  hdr_qd_next[7:0]     = b;
            4'd6:  anns_nz_next         = (b != 8'd0);
            [4'd7:4'd9]: anns_nz_next   = anns_nz || (b != 8'd0);
            4'd10: ar_hi_next           = b;
            default: ;
          endcase
          if (hdr_idx == HDR_LAST) begin
            hdr_idx_next    = 4'd0;
            res_valid       = 1'b1;
            res.word_a      = hdr_id;
            res.word_b      = hdr_qd;
            res.word_c      = {ar_hi, b};
            res.qr_bit      = hdr_flags[15];
            res.op_code     = hdr_flags[14:11];
            res.aa_bit      = hdr_flags[10];
            res.tc_bit      = hdr_flags[9];
            res.rd_bit      = hdr_flags[8];
            res.ra_bit      = hdr_flags[7];
            res.resp_code   = hdr_flags[3:0];
            if (anns_nz) begin
              res.event_res = EV_REJECT;
              phase_next    = PH_SKIP;
            end else begin
              res.event_res   = EV_HDR_OK;
              q_left_next     = hdr_qd;
              name_pos_next   = '0;
              label_left_next = '0;
              phase_next      = (hdr_qd == 16'd0) ? PH_SKIP : PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (label_left != 6'd0) begin
            res_valid = 1'b1;
            if (name_pos >= NPOS_LIMIT) begin
              res.event_res = EV_TOOLONG;
              phase_next    = PH_SKIP;
            end else begin
              res.event_res   = EV_CHAR;
              res.word_a      = {8'd0, b};
              label_left_next = label_left - 6'd1;
              name_pos_next   = name_pos + 1'b1;
            end
          end else if (b == 8'd0) begin
            // root label ends the name
            phase_next    = PH_TAIL;
            tail_next     = '0;
            tail_idx_next = '0;
          end else if (name_pos >= NPOS_LIMIT) begin
            res_valid     = 1'b1;
            res.event_res = EV_TOOLONG;
            phase_next    = PH_SKIP;
          end else if (b > MAX_LABEL_LEN) begin
            // also catches compression pointers
            res_valid     = 1'b1;
            res.event_res = EV_BADLABEL;
            phase_next    = PH_SKIP;
          end else begin
            // later labels are separated by a dot
            if (name_pos != '0) begin
              res_valid     = 1'b1;
              res.event_res = EV_CHAR;
              res.word_a    = 16'h002E;
            end
            label_left_next = b[5:0];
            name_pos_next   = name_pos + 1'b1;
          end
        end
        PH_TAIL: begin
          tail_next     = {tail[15:0], b};
          tail_idx_next = tail_idx + 2'd1;
          if (tail_idx == 2'd3) begin
            res_valid         = 1'b1;
            res.event_res     = EV_QDONE;
            res.word_a        = tail[23:8];
            res.word_b        = {tail[7:0], b};
            res.last_question = (q_left == 16'd1);
            q_left_next       = (q_left == 16'd0) ? 16'd0 : q_left - 16'd1;
            if (q_left <= 16'd1) begin
              phase_next = PH_SKIP;
            end else begin
              phase_next      = PH_NAME;
              name_pos_next   = '0;
              label_left_next = '0;
            end
          end
        end
        PH_SKIP: ;
        default: ;
      endcase

      if (s_tlast) begin
        // message ended before the parse finished
        if (phase_next != PH_SKIP) begin
          res           = '0;
          res.event_res = EV_TRUNC;
          res_valid     = 1'b1;
        end
        phase_next      = PH_HEADER;
        hdr_idx_next    = '0;
        q_left_next     = '0;
        name_pos_next   = '0;
        label_left_next = '0;
        tail_next       = '0;
        tail_idx_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_idx    <= '0;
      q_left     <= '0;
      name_pos   <= '0;
      label_left <= '0;
      tail_idx   <= '0;
    end else begin
      phase      <= phase_next;
      hdr_idx    <= hdr_idx_next;
      q_left     <= q_left_next;
      name_pos   <= name_pos_next;
      label_left <= label_left_next;
      tail_idx   <= tail_idx_next;
    end
  end

  // header and tail payload; fully rewritten before use
  always_ff @(posedge clk) begin
    hdr_id    <= hdr_id_next;
    hdr_flags <= hdr_flags_next;
    hdr_qd    <= hdr_qd_next;
    ar_hi     <= ar_hi_next;
    anns_nz   <= anns_nz_next;
    tail      <= tail_next;
  end

  // result register plus skid entry
  dqp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (buf_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {3'b000, out_res.resp_code, out_res.ra_bit, out_res.rd_bit,
                    out_res.tc_bit, out_res.aa_bit, out_res.op_code, out_res.qr_bit,
                    out_res.word_c, out_res.word_b, out_res.word_a};
  assign m_tuser = out_res.event_res;
  assign m_tlast = out_res.last_question;

endmodule

/* rtl/dqp_checker.sv */
module dqp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import dqp_pkg::*;

  logic ev_err;

  assign ev_err  = (m_tuser == EV_TOOLONG) || (m_tuser == EV_BADLABEL) ||
                   (m_tuser == EV_TRUNC);

  // last_question only ever flags a question-done transfer
  a_last_qdone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == EV_QDONE)
    else $error("last_question set on a non question-done event");

  // a name character carries one byte and nothing else
  a_char_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_CHAR |-> m_tdata[63:8] == 56'd0)
    else $error("name character event carries stray payload bits");

  // error events carry an empty payload
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ev_err |-> m_tdata == 64'd0 && !m_tlast)
    else $error("error event carries payload");

  // input is held off only behind a result that was stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
    else $error("input stalled with no result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind dns_query_parser dqp_checker u_dqp_checker (.*);

/* verif/tb_dns_query_parser.sv */
module tb_dns_query_parser;
  import dqp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  // random share; the directed messages add roughly another thousand bytes
  localparam int RANDOM_BYTES = 400;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Where the parser stands within the current message
  typedef enum logic [1:0] {
    HDR_PHASE,
    NAME_PHASE,
    TAIL_PHASE,
    SKIP_PHASE
  } parse_phase_t;

  // Mirrors the parser byte by byte and holds the events still to come out
  class dns_event_scoreboard;
    parse_phase_t phase;
    int           hdr_idx;
    logic [15:0]  hdr_word[6];
    logic [15:0]  q_left;
    int           name_pos;
    int           label_left;
    logic [31:0]  tail_acc;
    int           tail_idx;
    result_t      expected_events[$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = HDR_PHASE;
      hdr_idx = 0;
      foreach (hdr_word[i]) hdr_word[i] = '0;
      q_left = '0;
      name_pos = 0;
      label_left = 0;
      tail_acc = '0;
      tail_idx = 0;
    endfunction

    function result_t header_event(evt_t ev);
      result_t r;
      r = '0;
      r.event_res = ev;
      r.word_a    = hdr_word[0];
      r.word_b    = hdr_word[2];
      r.word_c    = hdr_word[5];
      r.qr_bit    = hdr_word[1][15];
      r.op_code   = hdr_word[1][14:11];
      r.aa_bit    = hdr_word[1][10];
      r.tc_bit    = hdr_word[1][9];
      r.rd_bit    = hdr_word[1][8];
      r.ra_bit    = hdr_word[1][7];
      r.resp_code = hdr_word[1][3:0];
      return r;
    endfunction

    // One accepted byte transfer in, zero or one expected event out
    function void note_byte(logic [7:0] b, logic last);
      result_t r;
      logic    hit;
      int      w;
      r = '0;
      hit = 1'b0;
      case (phase)
        HDR_PHASE: begin
          w = hdr_idx >> 1;
          if (hdr_idx % 2 == 0) hdr_word[w] = {b, 8'h00};
          else hdr_word[w][7:0] = b;
          hdr_idx++;
          if (hdr_idx >= HDR_BYTES) begin
            hdr_idx = 0;
            hit = 1'b1;
            if (hdr_word[3] != 0 || hdr_word[4] != 0) begin
              r = header_event(EV_REJECT);
              phase = SKIP_PHASE;
            end else begin
              r = header_event(EV_HDR_OK);
              q_left = hdr_word[2];
              name_pos = 0;
              label_left = 0;
              phase = (q_left == 0) ? SKIP_PHASE : NAME_PHASE;
            end
          end
        end
        NAME_PHASE: begin
          if (label_left != 0) begin
            hit = 1'b1;
            if (name_pos >= MAX_NAME_BYTES_DEF - 1) begin
              r.event_res = EV_TOOLONG;
              phase = SKIP_PHASE;
            end else begin
              r.event_res = EV_CHAR;
              r.word_a = {8'h00, b};
              label_left--;
              name_pos++;
            end
          end else if (b == 0) begin
            phase = TAIL_PHASE;
            tail_acc = '0;
            tail_idx = 0;
          end else if (name_pos >= MAX_NAME_BYTES_DEF - 1) begin
            // length check wins over the label check
            hit = 1'b1;
            r.event_res = EV_TOOLONG;
            phase = SKIP_PHASE;
          end else if (b > MAX_LABEL_LEN) begin
            hit = 1'b1;
            r.event_res = EV_BADLABEL;
            phase = SKIP_PHASE;
          end else begin
            // leading length byte is silent, later ones become a dot
            if (name_pos != 0) begin
              hit = 1'b1;
              r.event_res = EV_CHAR;
              r.word_a = {8'h00, DOT_CHAR};
            end
            label_left = b;
            name_pos++;
          end
        end
        TAIL_PHASE: begin
          tail_acc = {tail_acc[23:0], b};
          tail_idx++;
          if (tail_idx >= 4) begin
            tail_idx = 0;
            hit = 1'b1;
            r.event_res = EV_QDONE;
            r.word_a = tail_acc[31:16];
            r.word_b = tail_acc[15:0];
            r.last_question = (q_left == 1);
            if (q_left != 0) q_left--;
            if (q_left == 0) begin
              phase = SKIP_PHASE;
            end else begin
              phase = NAME_PHASE;
              name_pos = 0;
              label_left = 0;
            end
          end
        end
        default: phase = SKIP_PHASE;
      endcase
      if (last) begin
        if (phase != SKIP_PHASE) begin
          r = '0;
          r.event_res = EV_TRUNC;
          hit = 1'b1;
        end
        restart();
      end
      if (hit) expected_events.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        $error("event_res: expected none, got 0x%0h", got.event_res);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare("event_res", want.event_res, got.event_res);
      compare("word_a", want.word_a, got.word_a);
      compare("word_b", want.word_b, got.word_b);
      compare("word_c", want.word_c, got.word_c);
      compare("qr_bit", want.qr_bit, got.qr_bit);
      compare("op_code", want.op_code, got.op_code);
      compare("aa_bit", want.aa_bit, got.aa_bit);
      compare("tc_bit", want.tc_bit, got.tc_bit);
      compare("rd_bit", want.rd_bit, got.rd_bit);
      compare("ra_bit", want.ra_bit, got.ra_bit);
      compare("resp_code", want.resp_code, got.resp_code);
      compare("last_question", want.last_question, got.last_question);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // [15:0] word_a, [31:16] word_b, [47:32] word_c, [48] qr_bit,
                          // [52:49] op_code, [53] aa_bit, [54] tc_bit, [55] rd_bit,
                          // [56] ra_bit, [60:57] resp_code
  logic [2:0]  m_tuser;   // [2:0] event_res
  logic        m_tlast;   // last_question

  dns_event_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int useful_bytes = 0;

  dns_query_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Event sink, stalling at the rate of the current phase
  always @(posedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic result_t sample_event();
    result_t r;
    r.event_res     = evt_t'(m_tuser);
    r.word_a        = m_tdata[15:0];
    r.word_b        = m_tdata[31:16];
    r.word_c        = m_tdata[47:32];
    r.qr_bit        = m_tdata[48];
    r.op_code       = m_tdata[52:49];
    r.aa_bit        = m_tdata[53];
    r.tc_bit        = m_tdata[54];
    r.rd_bit        = m_tdata[55];
    r.ra_bit        = m_tdata[56];
    r.resp_code     = m_tdata[60:57];
    r.last_question = m_tlast;
    return r;
  endfunction

  // Both sides sampled at the edge, before this step's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_event(sample_event());
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  function automatic void add_word(ref logic [7:0] msg[$], input logic [15:0] w);
    msg.push_back(w[15:8]);
    msg.push_back(w[7:0]);
  endfunction

  function automatic void add_header(ref logic [7:0] msg[$], input logic [15:0] id,
                                     input logic [15:0] flags, input logic [15:0] qd,
                                     input logic [15:0] an, input logic [15:0] ns,
                                     input logic [15:0] ar);
    add_word(msg, id);
    add_word(msg, flags);
    add_word(msg, qd);
    add_word(msg, an);
    add_word(msg, ns);
    add_word(msg, ar);
  endfunction

  // Length byte plus that many random characters
  function automatic void add_label(ref logic [7:0] msg[$], input int len);
    msg.push_back(8'(len));
    repeat (len) msg.push_back(8'($urandom));
  endfunction

  // Three full labels, 192 name bytes, then one more label of the given length
  function automatic void add_long_name(ref logic [7:0] msg[$], input int last_len);
    repeat (3) add_label(msg, 63);
    add_label(msg, last_len);
  endfunction

  // Mostly well-formed queries with random content; some rejected, broken or cut short
  task automatic random_message();
    logic [7:0]  msg[$];
    logic [15:0] qd, an, ns;
    int          kind, nq, nlab, bad_at, cut;
    kind = $urandom_range(99);
    qd = 16'($urandom_range(1, 3));
    an = '0;
    ns = '0;
    if (kind < 5) qd = '0;
    else if (kind < 10) qd = 16'($urandom);
    else if (kind < 16) begin
      if ($urandom_range(1)) an = 16'($urandom_range(1, 16'hFFFF));
      else ns = 16'($urandom_range(1, 16'hFFFF));
    end
    add_header(msg, 16'($urandom), 16'($urandom), qd, an, ns, 16'($urandom));
    nq = (qd > 3) ? 3 : qd;
    for (int q = 0; q < nq; q++) begin
      nlab = $urandom_range(0, 4);
      bad_at = (kind >= 16 && kind < 24 && q == nq - 1) ? $urandom_range(0, nlab) : -1;
      for (int l = 0; l <= nlab; l++) begin
        if (l == bad_at) msg.push_back(8'($urandom_range(64, 255)));
        if (l < nlab) add_label(msg, ($urandom_range(15) == 0) ? 63 : $urandom_range(1, 10));
      end
      msg.push_back(8'h00);
      add_word(msg, 16'($urandom));
      add_word(msg, 16'($urandom));
    end
    if (kind >= 24 && kind < 34) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
    if (kind >= 34 && kind < 46) begin
      cut = $urandom_range(1, msg.size() - 1);
      msg = msg[0:cut-1];
    end
    useful_bytes += msg.size();
    send_message(msg);
  endtask

  initial begin
    logic [7:0] msg[$];
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling on either side.
    // All-ones header fields with a root name and all-ones type and class
    msg = {};
    add_header(msg, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    msg.push_back(8'h00);
    add_word(msg, 16'hFFFF);
    add_word(msg, 16'hFFFF);
    send_message(msg);
    // All-zero header: no questions, ends on the last header byte
    msg = {};
    add_header(msg, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
    send_message(msg);
    // Rejected on answer count, then on authority count
    msg = {};
    add_header(msg, 16'h1234, 16'h0100, 16'd1, 16'd1, 16'd0, 16'd0);
    msg.push_back(8'h05);
    send_message(msg);
    msg = {};
    add_header(msg, 16'h4321, 16'h8180, 16'd1, 16'd0, 16'hFFFF, 16'd2);
    send_message(msg);
    // Two questions, dotted names, the second one with a full 63-byte label
    msg = {};
    add_header(msg, 16'hBEEF, 16'h2A0F, 16'd2, 16'd0, 16'd0, 16'd1);
    add_label(msg, 1);
    add_label(msg, 2);
    msg.push_back(8'h00);
    add_word(msg, 16'h0001);
    add_word(msg, 16'h0001);
    add_label(msg, 63);
    msg.push_back(8'h00);
    add_word(msg, 16'h001C);
    add_word(msg, 16'h00FF);
    msg.push_back(8'hAA);
    send_message(msg);
    // Bad label as the first length byte, then a compression pointer mid-name
    msg = {};
    add_header(msg, 16'h0001, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    msg.push_back(8'h40);
    msg.push_back(8'h01);
    send_message(msg);
    msg = {};
    add_header(msg, 16'h0002, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    add_label(msg, 3);
    msg.push_back(8'hC0);
    msg.push_back(8'h0C);
    send_message(msg);
    // Early ends: single byte, inside the header, on the last header byte,
    // inside a name, inside type and class
    msg = {8'h7E};
    send_message(msg);
    msg = {};
    add_word(msg, 16'hA5A5);
    msg.push_back(8'h5A);
    send_message(msg);
    msg = {};
    add_header(msg, 16'h0003, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    send_message(msg);
    msg = {};
    add_header(msg, 16'h0004, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    add_label(msg, 2);
    send_message(msg);
    msg = {};
    add_header(msg, 16'h0005, 16'h0000, 16'd3, 16'd0, 16'd0, 16'd0);
    msg.push_back(8'h00);
    add_word(msg, 16'h0010);
    send_message(msg);
    // Longest legal name: 255 bytes with the terminator still accepted
    msg = {};
    add_header(msg, 16'h0006, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    add_long_name(msg, 62);
    msg.push_back(8'h00);
    add_word(msg, 16'h0002);
    add_word(msg, 16'h0003);
    send_message(msg);
    // One character too many
    msg = {};
    add_header(msg, 16'h0007, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    add_long_name(msg, 63);
    msg.push_back(8'h00);
    send_message(msg);
    // Length byte past the limit: too long takes precedence over bad label
    msg = {};
    add_header(msg, 16'h0008, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    add_long_name(msg, 62);
    msg.push_back(8'hC0);
    msg.push_back(8'h00);
    send_message(msg);

    // Random part across four pressure phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      while (useful_bytes < RANDOM_BYTES * (p + 1) / 4) random_message();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
